>>> rtl/auto_range_packing_quantizer_core_macros.svh
// Assertion macros shared by the auto-range packing quantizer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef AUTO_RANGE_PACKING_QUANTIZER_CORE_MACROS_SVH
`define AUTO_RANGE_PACKING_QUANTIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ARPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Expression must never be true outside reset
`define ARPQ_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ARPQ_ASSERT(lbl, clk, rst_n, prop)
`define ARPQ_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/arpq_pkg.sv
// Shared types and constants of the auto-range packing quantizer.
// No dependencies; used by arpq_range, arpq_div and the top level.
package arpq_pkg;

    // Command codes carried on the input tuser
    localparam int          CMD_W     = 2;
    localparam logic [1:0]  CMD_START = 2'd0;
    localparam logic [1:0]  CMD_SCAN  = 2'd1;
    localparam logic [1:0]  CMD_QUANT = 2'd2;

    // Result code width and the missing-sample code
    localparam int          CODE_W    = 16;
    localparam logic [15:0] CODE_MISS = 16'h8000;

    // Configuration port
    localparam int          CFG_W     = 32;
    localparam int          PADDR_W   = 3;
    localparam logic        REG_MISSING = 1'b0;  // word index of missing_marker

    // Control into the range tracker
    typedef struct packed {
        logic clear;   // start of a new grid
        logic scan;    // valid (non-missing) scan sample
    } t_rng_ctrl;

endpackage

>>> rtl/arpq_range.sv
// Running minimum / maximum tracker for the scan pass.
// Depends on arpq_pkg (t_rng_ctrl).
module arpq_range #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arpq_pkg::t_rng_ctrl            i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_min,
    output logic signed [SAMPLE_WIDTH-1:0] o_max,
    output logic                           o_any
);

    localparam logic [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic                           r_any;

    // Independent compares against both bounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_min <= MOST_POS;
            r_max <= MOST_NEG;
            r_any <= 1'b0;
        end else if (i_ctrl.scan) begin
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            r_any <= 1'b1;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
    assign o_any = r_any;

endmodule

>>> rtl/arpq_div.sv
// Shared scale unit: diff*CODE_MAX, restoring division by the range one
// quotient bit per cycle, then round half to even. Depends on arpq_pkg.
module arpq_div #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int CODE_MAX     = 32767
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [SAMPLE_WIDTH-1:0]       i_diff,   // x - min, below range
    input  logic [SAMPLE_WIDTH-1:0]       i_range,  // max - min, nonzero
    output logic                          o_done,
    output logic [arpq_pkg::CODE_W-1:0]   o_code
);

    localparam int QB    = $clog2(CODE_MAX + 1);
    localparam int PW    = SAMPLE_WIDTH + QB;
    localparam int CNT_W = $clog2(QB);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_DIV  = 2'd2;
    localparam logic [1:0] D_RND  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [SAMPLE_WIDTH-1:0] r_diff;
    logic [SAMPLE_WIDTH-1:0] r_range;
    logic [SAMPLE_WIDTH-1:0] r_rem;
    logic [QB-1:0]           r_low;
    logic [QB-1:0]           r_q;
    logic                    r_done;
    logic [arpq_pkg::CODE_W-1:0] r_code;

    logic [PW-1:0]           w_prod;
    logic [SAMPLE_WIDTH:0]   w_trial;
    logic [SAMPLE_WIDTH:0]   w_rng_ext;
    logic                    w_ge;
    logic [SAMPLE_WIDTH:0]   w_sub;
    logic [SAMPLE_WIDTH:0]   w_twice;
    logic                    w_up;
    logic [QB-1:0]           w_qr;

    // Datapath: the multiply happens only in D_MUL, one compare-subtract per step
    assign w_prod    = PW'(r_diff) * PW'(CODE_MAX);
    assign w_rng_ext = {1'b0, r_range};
    assign w_trial   = {r_rem, r_low[QB-1]};
    assign w_ge      = (w_trial >= w_rng_ext);
    assign w_sub     = w_trial - w_rng_ext;
    assign w_twice   = {r_rem, 1'b0};
    assign w_up      = (w_twice > w_rng_ext) || ((w_twice == w_rng_ext) && r_q[0]);
    assign w_qr      = r_q + QB'(w_up);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_state = D_MUL;
                end
            end
            D_MUL: n_state = D_DIV;
            D_DIV: begin
                if (r_cnt == '0) begin
                    n_state = D_RND;
                end
            end
            D_RND: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_RND);
        end
    end

    // Operand, remainder and quotient registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_diff  <= i_diff;
                    r_range <= i_range;
                end
            end
            D_MUL: begin
                // upper part is already below the range: quotient fits QB bits
                r_rem <= w_prod[PW-1:QB];
                r_low <= w_prod[QB-1:0];
                r_q   <= '0;
                r_cnt <= CNT_W'(QB - 1);
            end
            D_DIV: begin
                r_rem <= w_ge ? w_sub[SAMPLE_WIDTH-1:0] : w_trial[SAMPLE_WIDTH-1:0];
                r_low <= {r_low[QB-2:0], 1'b0};
                r_q   <= {r_q[QB-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            default: begin
                r_code <= arpq_pkg::CODE_W'(w_qr);
            end
        endcase
    end

    assign o_done = r_done;
    assign o_code = r_code;

endmodule

>>> rtl/auto_range_packing_quantizer_core.sv
// Auto-range packing quantizer:
//   Input stream: s_axis_tuser = command, s_axis_tdata = sample.
//     START clears the range, SCAN tracks min/max (missing marker skipped),
//     QUANT returns code = round((x-min)*CODE_MAX/(max-min)), ties to even,
//     plus the current min and max. START and SCAN give no output beat.
//   Output stream: one beat per QUANT, tdata = {range_high, range_low, code}.
//   Config: APB register 0 (byte address 0) holds the 32-bit missing marker.
//   Timing: START and SCAN keep the sequencer in ST_IDLE, so the next
//   beat may follow at once. QUANT with a special case (missing, empty
//   or zero range, sample at or beyond a bound) goes from ST_PREP
//   straight to ST_DONE; otherwise the scale unit runs one quotient bit
//   per cycle while in ST_DIV before ST_DONE. The input is not ready
//   while a QUANT beat is in work.
//   A finished result sits in an output register; while the receiver stalls,
//   beats are still taken and a further QUANT result waits in ST_DONE.
//   Reset (synchronous, active low) empties the range, sets the marker to 0
//   and drops the output valid.
`include "auto_range_packing_quantizer_core_macros.svh"
// Depends on arpq_pkg, arpq_range and arpq_div.
module auto_range_packing_quantizer_core #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int CODE_MAX     = 32767
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample
    input  logic [arpq_pkg::CMD_W-1:0]             s_axis_tuser,  // command
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // packed_value[15:0], range_low, range_high
    output logic [((16+2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [arpq_pkg::PADDR_W-1:0]           paddr,
    input  logic [arpq_pkg::CFG_W-1:0]             pwdata,
    output logic [arpq_pkg::CFG_W-1:0]             prdata,
    output logic                                   pready
);

    localparam int OUT_W = ((16 + 2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CW    = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32;
    localparam logic [arpq_pkg::CODE_W-1:0] CODE_TOP = arpq_pkg::CODE_W'(CODE_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic signed [31:0]             r_marker;
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic                           r_missing;
    logic [arpq_pkg::CODE_W-1:0]    r_code;
    logic                           r_m_valid;
    logic [arpq_pkg::CODE_W-1:0]    r_m_code;
    logic signed [SAMPLE_WIDTH-1:0] r_m_low;
    logic signed [SAMPLE_WIDTH-1:0] r_m_high;

    logic signed [SAMPLE_WIDTH-1:0] w_sample;
    logic [arpq_pkg::CMD_W-1:0]     w_cmd;
    logic                           w_acc;
    logic                           w_is_miss;
    logic signed [CW-1:0]           w_x_ext;
    logic signed [CW-1:0]           w_mk_ext;
    arpq_pkg::t_rng_ctrl            w_rng;
    logic signed [SAMPLE_WIDTH-1:0] w_min;
    logic signed [SAMPLE_WIDTH-1:0] w_max;
    logic                           w_any;
    logic                           w_flat;
    logic                           w_le_min;
    logic                           w_ge_max;
    logic                           w_special;
    logic [arpq_pkg::CODE_W-1:0]    w_sp_code;
    logic [SAMPLE_WIDTH-1:0]        w_diff;
    logic [SAMPLE_WIDTH-1:0]        w_range;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [arpq_pkg::CODE_W-1:0]    w_div_code;
    logic                           w_out_free;

    // Input beat decode
    assign w_sample = $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign w_cmd    = s_axis_tuser;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc    = s_axis_tvalid && s_axis_tready;

    // Missing-marker compare on sign-extended values
    assign w_x_ext   = CW'(w_sample);
    assign w_mk_ext  = CW'(r_marker);
    assign w_is_miss = (w_x_ext == w_mk_ext);

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == arpq_pkg::REG_MISSING) ? r_marker : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == arpq_pkg::REG_MISSING)) begin
            r_marker <= pwdata;
        end
    end

    // Range tracker
    assign w_rng.clear = w_acc && (w_cmd == arpq_pkg::CMD_START);
    assign w_rng.scan  = w_acc && (w_cmd == arpq_pkg::CMD_SCAN) && !w_is_miss;

    arpq_range #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_range (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_rng),
        .i_sample (w_sample),
        .o_min    (w_min),
        .o_max    (w_max),
        .o_any    (w_any)
    );

    // Classification of a quantize sample and divider operands
    assign w_flat    = !w_any || (w_max == w_min);
    assign w_le_min  = !(w_min < r_x);
    assign w_ge_max  = !(r_x < w_max);
    assign w_special = r_missing || w_flat || w_le_min || w_ge_max;
    assign w_diff    = r_x - w_min;
    assign w_range   = w_max - w_min;

    always_comb begin
        if (r_missing) begin
            w_sp_code = arpq_pkg::CODE_MISS;
        end else if (w_flat || w_le_min) begin
            w_sp_code = '0;
        end else begin
            w_sp_code = CODE_TOP;
        end
    end

    assign w_div_start = (r_state == ST_PREP) && !w_special;

    arpq_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CODE_MAX     (CODE_MAX)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (w_diff),
        .i_range (w_range),
        .o_done  (w_div_done),
        .o_code  (w_div_code)
    );

    // Sequencer
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (w_cmd == arpq_pkg::CMD_QUANT)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = w_special ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Quantize sample capture and code register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x       <= w_sample;
            r_missing <= w_is_miss;
        end
        if (r_state == ST_PREP) begin
            r_code <= w_sp_code;
        end else if ((r_state == ST_DIV) && w_div_done) begin
            r_code <= w_div_code;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_m_code <= r_code;
            r_m_low  <= w_min;
            r_m_high <= w_max;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_m_high, r_m_low, r_m_code});

    // Checks
    `ARPQ_ASSERT(a_quant_enters_prep, i_clk, i_rst_n,
        (w_acc && (w_cmd == arpq_pkg::CMD_QUANT)) |=> (r_state == ST_PREP))
    `ARPQ_ASSERT(a_div_done_in_div, i_clk, i_rst_n,
        w_div_done |-> (r_state == ST_DIV))
    `ARPQ_ASSERT(a_out_from_done, i_clk, i_rst_n,
        $rose(r_m_valid) |-> ($past(r_state) == ST_DONE))
    `ARPQ_NEVER(a_range_order, i_clk, i_rst_n,
        w_any && (w_max < w_min))

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for auto_range_packing_quantizer_core: streams start, scan, quantize and
// unknown beats, predicts each code and range with its own model, and checks every result beat.
// Depends on arpq_pkg and the RTL of the core.
module tb_top;

    localparam logic [arpq_pkg::CMD_W-1:0]   CMD_BAD     = 2'd3;   // unknown command, ignored
    localparam logic [arpq_pkg::PADDR_W-1:0] MARKER_ADDR = {arpq_pkg::REG_MISSING, 2'b00};
    localparam int                 CODE_TOP     = 32767;
    localparam int                 SAMPLE_TOP   = 32'h7fff_ffff;
    localparam int                 SAMPLE_BOT   = 32'h8000_0000;
    localparam int                 DRAIN_CYCLES = 30;
    localparam int                 STALL_LIMIT  = 5000;

    typedef struct packed {
        logic [15:0] code;
        logic [31:0] low;
        logic [31:0] high;
    } t_quant_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;     // sample
    logic [1:0]  s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;     // packed_value[15:0], range_low[47:16], range_high[79:48]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [arpq_pkg::PADDR_W-1:0] paddr;
    logic [arpq_pkg::CFG_W-1:0]   pwdata;
    logic [arpq_pkg::CFG_W-1:0]   prdata;
    logic        pready;

    // Predicted block state
    int  marker;
    int  run_min;
    int  run_max;
    bit  range_valid;

    t_quant_result pending_codes[$];
    int  src_idle_pct;
    int  snk_idle_pct;
    int  err_cnt;
    int  quiet_cycles;

    auto_range_packing_quantizer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // round((x - min) * CODE_TOP / (max - min)), ties to even; needs min < x < max
    function automatic logic [15:0] scale_code(int x);
        longint unsigned diff, span, num, q, r;
        diff = longint'(x) - longint'(run_min);
        span = longint'(run_max) - longint'(run_min);
        num  = diff * CODE_TOP;
        q    = num / span;
        r    = num % span;
        if (2 * r > span || (2 * r == span && q[0]))
            q = q + 1;
        return q[15:0];
    endfunction

    // Update the range tracker for one accepted beat and queue any result
    function automatic void apply_beat(logic [1:0] cmd, int x);
        t_quant_result res;
        case (cmd)
            arpq_pkg::CMD_START: begin
                run_min     = SAMPLE_TOP;
                run_max     = SAMPLE_BOT;
                range_valid = 1'b0;
            end
            arpq_pkg::CMD_SCAN: begin
                if (x != marker) begin
                    if (x < run_min)
                        run_min = x;
                    if (x > run_max)
                        run_max = x;
                    range_valid = 1'b1;
                end
            end
            arpq_pkg::CMD_QUANT: begin
                if (x == marker)
                    res.code = arpq_pkg::CODE_MISS;
                else if (!range_valid || run_max == run_min)
                    res.code = '0;
                else if (x <= run_min)
                    res.code = '0;
                else if (x >= run_max)
                    res.code = 16'(CODE_TOP);
                else
                    res.code = scale_code(x);
                res.low  = run_min;
                res.high = run_max;
                pending_codes.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Offer one beat, with random idle cycles ahead of it
    task automatic send_beat(logic [1:0] cmd, int x);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_beat(cmd, x);
    endtask

    // Let every queued result come out, then allow the pipeline to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write the missing marker, then read it back in a back-to-back transfer
    task automatic set_marker(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MARKER_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        marker = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $error("missing_marker readback mismatch: expected %h, got %h", value, prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly values clustered around a center, plus marker, bounds and wide values
    function automatic int pick_sample(int center, int spread);
        case ($urandom_range(9))
            0: return marker;
            1: begin
                case ($urandom_range(3))
                    0:       return SAMPLE_TOP;
                    1:       return SAMPLE_BOT;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            2, 3: return $urandom;
            4: return $urandom_range(1) ? run_max : run_min;
            default: return center + int'($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    task automatic test_directed();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // nothing scanned yet, then the reset marker
        send_beat(arpq_pkg::CMD_QUANT, 1234);
        send_beat(arpq_pkg::CMD_QUANT, 0);
        // full 32-bit range, marker scan skipped
        send_beat(arpq_pkg::CMD_START, 0);
        send_beat(arpq_pkg::CMD_SCAN, SAMPLE_BOT);
        send_beat(arpq_pkg::CMD_SCAN, SAMPLE_TOP);
        send_beat(arpq_pkg::CMD_SCAN, 0);
        send_beat(arpq_pkg::CMD_QUANT, SAMPLE_BOT);
        send_beat(arpq_pkg::CMD_QUANT, SAMPLE_TOP);
        send_beat(arpq_pkg::CMD_QUANT, 1);
        send_beat(CMD_BAD, 32'h5a5a_5a5a);
        send_beat(arpq_pkg::CMD_QUANT, -1);
        // zero range, then a half-way tie rounding up
        send_beat(arpq_pkg::CMD_START, -1);
        send_beat(arpq_pkg::CMD_SCAN, 10);
        send_beat(arpq_pkg::CMD_QUANT, 10);
        send_beat(arpq_pkg::CMD_SCAN, 12);
        send_beat(arpq_pkg::CMD_QUANT, 11);
        // tie rounding down, below and above the range
        send_beat(arpq_pkg::CMD_START, 0);
        send_beat(arpq_pkg::CMD_SCAN, 100);
        send_beat(arpq_pkg::CMD_SCAN, 65634);
        send_beat(arpq_pkg::CMD_QUANT, 101);
        send_beat(arpq_pkg::CMD_QUANT, 103);
        send_beat(arpq_pkg::CMD_QUANT, 50);
        send_beat(arpq_pkg::CMD_QUANT, 70000);
        drain();
    endtask

    task automatic test_marker_values();
        int vals[4];
        vals[0] = SAMPLE_BOT;
        vals[1] = SAMPLE_TOP;
        vals[2] = -1;
        vals[3] = $urandom;
        src_idle_pct = 20;
        snk_idle_pct = 20;
        foreach (vals[i]) begin
            set_marker(vals[i]);
            send_beat(arpq_pkg::CMD_START, $urandom);
            send_beat(arpq_pkg::CMD_SCAN, vals[i]);
            send_beat(arpq_pkg::CMD_SCAN, $urandom);
            send_beat(arpq_pkg::CMD_SCAN, vals[i] ^ 32'h1);
            send_beat(arpq_pkg::CMD_QUANT, vals[i]);
            send_beat(arpq_pkg::CMD_QUANT, $urandom);
            drain();
        end
    endtask

    // Well-formed grids with random content, with some stray beats in between
    task automatic run_grids(int n_items, int src_pct, int snk_pct);
        int          sent;
        int          n_scan;
        int          n_quant;
        int          center;
        int          spread;
        logic [1:0]  cmd;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                cmd = 2'($urandom_range(3));
                send_beat(cmd, $urandom);
                if (cmd != CMD_BAD)
                    sent++;
            end else begin
                center = $urandom;
                case ($urandom_range(2))
                    0:       spread = 3;
                    1:       spread = 2000;
                    default: spread = 1 << 24;
                endcase
                n_scan  = $urandom_range(1, 6);
                n_quant = $urandom_range(1, 8);
                send_beat(arpq_pkg::CMD_START, $urandom);
                repeat (n_scan) send_beat(arpq_pkg::CMD_SCAN, pick_sample(center, spread));
                repeat (n_quant) begin
                    cmd = ($urandom_range(4) == 0) ? arpq_pkg::CMD_SCAN : arpq_pkg::CMD_QUANT;
                    send_beat(cmd, pick_sample(center, spread));
                end
                sent += 1 + n_scan + n_quant;
            end
        end
        drain();
    endtask

    task automatic test_random_traffic();
        int marks[8];
        marks[0] = 0;
        marks[1] = SAMPLE_BOT;
        marks[2] = SAMPLE_TOP;
        for (int i = 3; i < 8; i++)
            marks[i] = $urandom;
        for (int ph = 0; ph < 8; ph++) begin
            set_marker(marks[ph]);
            case (ph % 4)
                0:       run_grids(215, 0, 0);
                1:       run_grids(215, 60, 0);
                2:       run_grids(215, 0, 60);
                default: run_grids(215, 20, 20);
            endcase
        end
    endtask

    // Output beat checker
    always @(posedge i_clk) begin : check_result
        t_quant_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected result beat: tdata %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[15:0] !== want.code) begin
                    $error("packed_value mismatch: expected %0d, got %0d",
                           $signed(want.code), $signed(m_axis_tdata[15:0]));
                    err_cnt++;
                end
                if (m_axis_tdata[47:16] !== want.low) begin
                    $error("range_low mismatch: expected %0d, got %0d",
                           $signed(want.low), $signed(m_axis_tdata[47:16]));
                    err_cnt++;
                end
                if (m_axis_tdata[79:48] !== want.high) begin
                    $error("range_high mismatch: expected %0d, got %0d",
                           $signed(want.high), $signed(m_axis_tdata[79:48]));
                    err_cnt++;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Watchdog on cycles with no beat and no register access
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("auto_range_packing_quantizer_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= arpq_pkg::CMD_START;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        marker       = 0;
        run_min      = SAMPLE_TOP;
        run_max      = SAMPLE_BOT;
        range_valid  = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        err_cnt      = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_marker_values();
        test_random_traffic();

        if (err_cnt == 0)
            $display("auto_range_packing_quantizer_core verification clean");
        else
            $display("auto_range_packing_quantizer_core verification failed");
        $finish;
    end

endmodule
